FILE: rtl/imd_pkg.sv
// ----------------------------------------------------------------------------
// imd_pkg: shared types and constants of the integer multiply/divide unit
// Word width, command codes, sequencer states and the control bundle that
// the sequencer sends to the datapath.
// ----------------------------------------------------------------------------
package imd_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned CmdWidth  = 3;
  localparam int unsigned CntWidth  = $clog2(DataWidth);

  // input item: command, operand_a, operand_b packed from bit 0, padded to bytes
  localparam int unsigned InBits   = CmdWidth + 2 * DataWidth;
  localparam int unsigned InTdataW = ((InBits + 7) / 8) * 8;
  localparam int unsigned OutTdataW = ((DataWidth + 7) / 8) * 8;

  typedef enum logic [CmdWidth-1:0] {
    CmdMul  = 3'd0,
    CmdDivu = 3'd1,
    CmdRemu = 3'd2,
    CmdDiv  = 3'd3,
    CmdRem  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StFix
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic fix;
  } imd_ctrl_t;

endpackage

FILE: rtl/imd_datapath.sv
// ----------------------------------------------------------------------------
// imd_datapath: operand registers and the shared add/subtract unit
// Shift-add multiply and restoring divide, one bit per step, then a
// sign fixup step through the same adder.
// ----------------------------------------------------------------------------
module imd_datapath
  import imd_pkg::*;
(
  input  logic                 clk_i,
  input  imd_ctrl_t            ctrl_i,
  input  cmd_e                 cmd_i,
  input  logic [DataWidth-1:0] opa_i,
  input  logic [DataWidth-1:0] opb_i,
  output logic [DataWidth-1:0] result_o
);

  cmd_e                 cmd_q;
  logic [DataWidth:0]   acc_q;   // product or partial remainder
  logic [DataWidth-1:0] x_q;     // multiplier / dividend -> quotient
  logic [DataWidth-1:0] y_q;     // multiplicand / divisor
  logic                 neg_q;
  logic                 zero_q;

  logic                 sign_a, sign_b;
  logic [DataWidth-1:0] mag_a, mag_b;
  logic                 is_mul, is_quo;
  logic [DataWidth:0]   add_a, add_b, sum;
  logic                 add_sub;
  logic [DataWidth-1:0] sel;

  assign sign_a = opa_i[DataWidth-1];
  assign sign_b = opb_i[DataWidth-1];
  assign mag_a  = sign_a ? (~opa_i + 1'b1) : opa_i;
  assign mag_b  = sign_b ? (~opb_i + 1'b1) : opb_i;

  assign is_mul = (cmd_q == CmdMul);
  assign is_quo = cmd_q inside {CmdDivu, CmdDiv};
  assign sel    = is_quo ? x_q : acc_q[DataWidth-1:0];

  // shared adder
  always_comb begin
    add_a   = acc_q;
    add_b   = {1'b0, y_q};
    add_sub = 1'b0;
    if (ctrl_i.fix) begin
      add_a   = '0;
      add_b   = {1'b0, sel};
      add_sub = 1'b1;
    end else if (!is_mul) begin
      add_a   = {acc_q[DataWidth-1:0], x_q[DataWidth-1]};
      add_sub = 1'b1;
    end
  end

  assign sum = add_a + (add_sub ? ~add_b : add_b) + {{DataWidth{1'b0}}, add_sub};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= cmd_i;
      acc_q <= '0;
      case (cmd_i)
        CmdMul: begin
          x_q    <= opa_i;
          y_q    <= opb_i;
          neg_q  <= 1'b0;
          zero_q <= 1'b0;
        end
        CmdDivu, CmdRemu: begin
          x_q    <= opa_i;
          y_q    <= opb_i;
          neg_q  <= 1'b0;
          zero_q <= (opb_i == '0);
        end
        CmdDiv: begin
          x_q    <= mag_a;
          y_q    <= mag_b;
          neg_q  <= sign_a ^ sign_b;
          zero_q <= (opb_i == '0);
        end
        CmdRem: begin
          x_q    <= mag_a;
          y_q    <= mag_b;
          neg_q  <= sign_a;
          zero_q <= (opb_i == '0);
        end
        default: begin
          x_q    <= opa_i;
          y_q    <= opb_i;
          neg_q  <= 1'b0;
          zero_q <= 1'b1;
        end
      endcase
    end else if (ctrl_i.step) begin
      if (is_mul) begin
        if (x_q[0]) begin
          acc_q <= {1'b0, sum[DataWidth-1:0]};
        end
        x_q <= x_q >> 1;
        y_q <= y_q << 1;
      end else begin
        acc_q <= sum[DataWidth] ? add_a : sum;
        x_q   <= {x_q[DataWidth-2:0], ~sum[DataWidth]};
      end
    end
  end

  always_comb begin
    if (zero_q) begin
      result_o = '0;
    end else if (neg_q) begin
      result_o = sum[DataWidth-1:0];
    end else begin
      result_o = sel;
    end
  end

endmodule

FILE: rtl/int_mul_div_unit.sv
// ----------------------------------------------------------------------------
// int_mul_div_unit: iterative 32-bit integer multiply/divide unit
// Low product, unsigned and signed quotient and remainder on one shared
// adder, one bit per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command item: command, operand_a, operand_b.
//   m_axis returns one 32-bit result item per command.
//   An item is accepted only while the unit is idle. The operands load at
//   the accepting edge. The item then runs through the bit-serial loop of
//   the shared add/subtract unit, one bit per step, and a sign fixup
//   step, after which the result sits in the output register. The unit
//   takes no new item until the sequencer is back in idle.
//   The output register separates the two sides: the next item is accepted
//   while a result still waits. If the receiver stalls, the unit holds in
//   the fixup step until the output register is free, so no result is lost.
//   Division by zero and unused command codes return 0.
//   Reset empties the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module int_mul_div_unit
  import imd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [InTdataW-1:0]  s_axis_tdata_i,   // command[2:0], operand_a, operand_b
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutTdataW-1:0] m_axis_tdata_o    // result
);

  state_e                state_q, state_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic [DataWidth-1:0]  out_data_q;
  imd_ctrl_t             ctrl;
  logic [DataWidth-1:0]  dp_result;
  logic                  in_accept;

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    ctrl            = '0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      StIdle: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          ctrl.load = 1'b1;
          cnt_d     = '0;
          state_d   = StRun;
        end
      end
      StRun: begin
        ctrl.step = 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CntWidth'(DataWidth - 1)) begin
          state_d = StFix;
        end
      end
      StFix: begin
        if (!out_valid_q || m_axis_tready_i) begin
          ctrl.fix = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.fix) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.fix) begin
      out_data_q <= dp_result;
    end
  end

  imd_datapath u_datapath (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .cmd_i    (cmd_e'(s_axis_tdata_i[CmdWidth-1:0])),
    .opa_i    (s_axis_tdata_i[CmdWidth +: DataWidth]),
    .opb_i    (s_axis_tdata_i[CmdWidth + DataWidth +: DataWidth]),
    .result_o (dp_result)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutTdataW'(out_data_q);

`ifndef SYNTHESIS
  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == StRun) && (cnt_q == '0))
    else $error("accepted item did not start the loop");

  a_fix_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.fix |=> m_axis_tvalid_o)
    else $error("fixup did not fill the output register");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFix) && m_axis_tvalid_o && !m_axis_tready_i |=> (state_q == StFix))
    else $error("pending result overwritten");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) || (state_q == StFix) |-> !in_accept)
    else $error("item accepted while busy");
`endif

endmodule

FILE: dv/int_mul_div_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_mul_div_unit_test: self-checking bench for the multiply/divide unit
// Drives command items on the input stream and compares every result with
// a predictor of the low product and the unsigned and signed quotient and
// remainder. It covers divide by zero, most negative operands and unused
// command codes, with random stalls on both streams.
// ----------------------------------------------------------------------------
module int_mul_div_unit_test
  import imd_pkg::*;
();

  localparam logic [CmdWidth-1:0] CmdRsvd5 = 3'd5;
  localparam logic [CmdWidth-1:0] CmdRsvd6 = 3'd6;
  localparam logic [CmdWidth-1:0] CmdRsvd7 = 3'd7;
  localparam logic [DataWidth-1:0] MinInt  = {1'b1, {(DataWidth-1){1'b0}}};
  localparam logic [DataWidth-1:0] MaxInt  = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic [DataWidth-1:0] AllOnes = {DataWidth{1'b1}};
  localparam int unsigned NumRandom = 850;
  localparam int unsigned QuietFrom = 720;

  class mul_div_scoreboard;
    logic [DataWidth-1:0] result_q[$];
    int unsigned          errors;
    int unsigned          checked;

    function logic [DataWidth-1:0] predict_word(logic [CmdWidth-1:0] cmd,
                                                logic [DataWidth-1:0] a,
                                                logic [DataWidth-1:0] b);
      logic [DataWidth-1:0] mag_a;
      logic [DataWidth-1:0] mag_b;
      logic [DataWidth-1:0] word;
      mag_a = a[DataWidth-1] ? -a : a;
      mag_b = b[DataWidth-1] ? -b : b;
      word  = '0;
      case (cmd)
        CmdMul:  word = a * b;
        CmdDivu: word = (b == 0) ? '0 : a / b;
        CmdRemu: word = (b == 0) ? '0 : a % b;
        CmdDiv: begin
          word = (mag_b == 0) ? '0 : mag_a / mag_b;
          if (a[DataWidth-1] != b[DataWidth-1]) word = -word;
        end
        CmdRem: begin
          word = (mag_b == 0) ? '0 : mag_a % mag_b;
          if (a[DataWidth-1]) word = -word;
        end
        default: word = '0;
      endcase
      return word;
    endfunction

    function void note_command(logic [CmdWidth-1:0] cmd, logic [DataWidth-1:0] a,
                               logic [DataWidth-1:0] b);
      result_q.push_back(predict_word(cmd, a, b));
    endfunction

    function int unsigned outstanding();
      return result_q.size();
    endfunction

    task report_mismatch(string what, logic [DataWidth-1:0] want,
                         logic [DataWidth-1:0] got);
      $display("ERROR @%0t: %s: expected %h, got %h", $realtime, what, want, got);
      errors++;
    endtask

    task check_result(logic [DataWidth-1:0] got);
      logic [DataWidth-1:0] want;
      checked++;
      if (result_q.size() == 0) begin
        report_mismatch("result with no command outstanding", 'x, got);
      end else begin
        want = result_q.pop_front();
        if (got !== want) report_mismatch("result", want, got);
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [InTdataW-1:0]  s_axis_tdata_i  = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata_o;

  mul_div_scoreboard board = new();
  bit                quiet;
  int unsigned       cmd_count[8];

  int_mul_div_unit i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Timeout: results still outstanding: %0d", board.outstanding());
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      board.check_result(m_axis_tdata_o[DataWidth-1:0]);
    end
  end

  // receiver: random stall bursts until the quiet tail
  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  end

  task automatic idle_sender(int unsigned cycles);
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= InTdataW'({$urandom, $urandom, $urandom});
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic send_item(logic [CmdWidth-1:0] cmd, logic [DataWidth-1:0] a,
                           logic [DataWidth-1:0] b);
    if (!quiet && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 14));
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(InTdataW-InBits){1'b0}}, b, a, cmd};
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_command(cmd, a, b);
    cmd_count[cmd]++;
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DataWidth-1:0] pick_operand();
    logic [DataWidth-1:0] word;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: word = $urandom;
      4, 5:       word = $urandom_range(0, 255);
      6:          word = -$urandom_range(1, 255);
      7: begin
        case ($urandom_range(0, 4))
          0:       word = MinInt;
          1:       word = MaxInt;
          2:       word = AllOnes;
          3:       word = 1;
          default: word = 0;
        endcase
      end
      8:          word = $urandom >> $urandom_range(0, DataWidth - 1);
      default:    word = 0;
    endcase
    return word;
  endfunction

  initial begin
    logic [CmdWidth-1:0] cmd;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, divide by zero, most negative operand, signs, unused codes
    send_item(CmdMul,  AllOnes,      AllOnes);
    send_item(CmdMul,  MinInt,       AllOnes);
    send_item(CmdMul,  32'h12345678, 32'h9abcdef0);
    send_item(CmdMul,  0,            MaxInt);
    send_item(CmdDivu, AllOnes,      0);
    send_item(CmdRemu, AllOnes,      0);
    send_item(CmdDiv,  MinInt,       0);
    send_item(CmdRem,  -7,           0);
    send_item(CmdDiv,  MinInt,       AllOnes);
    send_item(CmdRem,  MinInt,       AllOnes);
    send_item(CmdDiv,  MinInt,       MinInt);
    send_item(CmdDiv,  5,            MinInt);
    send_item(CmdRem,  MaxInt,       MinInt);
    send_item(CmdDiv,  -7,           2);
    send_item(CmdRem,  -7,           2);
    send_item(CmdDiv,  7,            -2);
    send_item(CmdRem,  7,            -2);
    send_item(CmdDiv,  -7,           -2);
    send_item(CmdRem,  -7,           -2);
    send_item(CmdDivu, AllOnes,      1);
    send_item(CmdRemu, AllOnes,      32'h10);
    send_item(CmdDivu, MinInt,       MinInt);
    send_item(CmdRsvd5, AllOnes,     3);
    send_item(CmdRsvd6, MaxInt,      MinInt);
    send_item(CmdRsvd7, 12,          AllOnes);
    drain_results();

    for (int unsigned n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) drain_results();
      if (n == QuietFrom) quiet = 1'b1;
      if ($urandom_range(0, 19) == 0) cmd = CmdWidth'($urandom_range(CmdRsvd5, CmdRsvd7));
      else                            cmd = CmdWidth'($urandom_range(CmdMul, CmdRem));
      send_item(cmd, pick_operand(), pick_operand());
    end

    drain_results();
    repeat (80) @(posedge clk_i);
    $display("Checked %0d results: mul %0d, divu %0d, remu %0d, div %0d, rem %0d,",
             board.checked, cmd_count[CmdMul], cmd_count[CmdDivu],
             cmd_count[CmdRemu], cmd_count[CmdDiv], cmd_count[CmdRem]);
    $display("unused codes %0d; includes zero divisors, most negative operands, stalls",
             cmd_count[CmdRsvd5] + cmd_count[CmdRsvd6] + cmd_count[CmdRsvd7]);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
